### src/rsas_pkg.sv
// shared types and constants for the rotated sorted array search block
// no dependencies; imported by every module of the block
`default_nettype none

package rsas_pkg;

   localparam int RSAS_MAX_ELEMENTS = 64;
   localparam int VALUE_W           = 32;
   localparam int POS_W             = 6;

   // request kind, carried in req_tuser[0]
   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   // response status, carried in rsp_tuser
   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NOTFOUND = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST,
      ST_FIRST,
      ST_PIV_RD,
      ST_PIV_CMP,
      ST_PV,
      ST_DEC,
      ST_SR_RD,
      ST_SR_CMP,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

### src/rsas_store.sv
// element memory and element count for the rotated sorted array search
// depends on rsas_pkg; one write port for appends, one registered read port
`default_nettype none

module rsas_store
   import rsas_pkg::*;
#(
   parameter int MAX_ELEMENTS = RSAS_MAX_ELEMENTS,
   localparam int AW = $clog2(MAX_ELEMENTS),
   localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               append_en,
   input  wire logic               append_restart,
   input  wire logic [VALUE_W-1:0] append_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [VALUE_W-1:0] rd_data,
   output logic      [CW-1:0]      count
);

   logic [VALUE_W-1:0] mem [MAX_ELEMENTS];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      wr_slot;
   logic               wr_en;

   // restart empties the array first, so the element lands in slot zero
   always_comb begin
      wr_slot  = append_restart ? '0 : count_ff;
      wr_en    = append_en && (wr_slot < CW'(MAX_ELEMENTS));
      count_in = count_ff;
      if (wr_en) begin
         count_in = wr_slot + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot[AW-1:0]] <= append_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule

`default_nettype wire

### src/rotated_sorted_array_search.sv
// top level of the rotated sorted array search block
// depends on rsas_pkg and rsas_store
//
// usage
//   request channel (req_): req_tuser[0] is the operation (0 append, 1 search),
//   req_tuser[1] is restart, req_tdata is the signed 32-bit value
//   append: stores the value at the end of the array, restart empties it
//   first; appends beyond MAX_ELEMENTS are dropped; no response
//   search: one response on rsp_ with rsp_tuser the status (found, not found,
//   empty) and rsp_tdata[5:0] the index when found, else zero
// sequencing
//   an append is taken while idle and leaves the sequencer idle; a search walks
//   one shared signed comparator and the single memory read port, with a read
//   state and a compare state for each binary-search step
//   req_tready is high only while the sequencer is idle
// reset
//   synchronous, active high; empties the array and drops any response
// stall
//   the response sits in an output register; a new request is taken while it
//   waits, and a later search holds its result until that register is free
`default_nettype none

module rotated_sorted_array_search
   import rsas_pkg::*;
#(
   parameter int MAX_ELEMENTS = RSAS_MAX_ELEMENTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // value[31:0]
   input  wire logic [1:0]  req_tuser,  // operation[0], restart[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,  // position[5:0], zero[7:6]
   output logic      [1:0]  rsp_tuser   // status[1:0]
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   state_type          state_ff, state_in;
   logic [AW-1:0]      lo_ff, lo_in;
   logic [AW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] last_ff, last_in;     // element n-1
   logic [VALUE_W-1:0] hi_val_ff, hi_val_in; // element at hi during pivot search
   logic               below_ff, below_in;   // key below the pivot element
   status_type         res_status_ff, res_status_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic               req_accept;
   logic               append_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [CW-1:0]      count;
   logic [CW-1:0]      last_full;
   logic [AW-1:0]      last_idx;
   logic [AW:0]        mid_sum;
   logic [AW-1:0]      mid_calc;
   logic               out_free;

   // the one shared compare unit
   logic signed [VALUE_W-1:0] cmp_a, cmp_b;
   logic                      cmp_eq, cmp_lt;

   // index to the 6-bit position field, low bits kept
   function automatic logic [POS_W-1:0] pos_of(input logic [AW-1:0] idx);
      logic [AW+POS_W-1:0] ext;
      ext = {{POS_W{1'b0}}, idx};
      return ext[POS_W-1:0];
   endfunction

   rsas_store #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_store (
      .clock          (clock),
      .reset          (reset),
      .append_en      (append_en),
      .append_restart (req_tuser[1]),
      .append_data    (req_tdata),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .count          (count)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign last_full  = count - CW'(1);
   assign last_idx   = last_full[AW-1:0];
   // lo + (hi - lo) / 2 with lo <= hi
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc   = mid_sum[AW:1];

   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      last_in       = last_ff;
      hi_val_in     = hi_val_ff;
      below_in      = below_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rd_addr       = last_idx;
      cmp_a         = key_ff;
      cmp_b         = rd_data;
      append_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // read of the last element is issued here, ready for the search
            if (req_accept) begin
               if (req_tuser[0] == OP_APPEND) begin
                  append_en = 1'b1;
               end else begin
                  key_in = req_tdata;
                  if (count == '0) begin
                     res_status_in = STATUS_EMPTY;
                     res_pos_in    = '0;
                     state_in      = ST_RESULT;
                  end else begin
                     state_in = ST_LAST;
                  end
               end
            end
         end
         ST_LAST: begin
            last_in   = rd_data;
            hi_val_in = rd_data;
            rd_addr   = '0;
            if (cmp_eq) begin
               res_status_in = STATUS_FOUND;
               res_pos_in    = pos_of(last_idx);
               state_in      = ST_RESULT;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (cmp_eq) begin
               res_status_in = STATUS_FOUND;
               res_pos_in    = '0;
               state_in      = ST_RESULT;
            end else begin
               lo_in    = '0;
               hi_in    = last_idx;
               state_in = ST_PIV_RD;
            end
         end
         ST_PIV_RD: begin
            // rotation point search ends when lo meets hi
            if (lo_ff < hi_ff) begin
               rd_addr  = mid_calc;
               mid_in   = mid_calc;
               state_in = ST_PIV_CMP;
            end else begin
               rd_addr  = lo_ff;
               state_in = ST_PV;
            end
         end
         ST_PIV_CMP: begin
            cmp_a = hi_val_ff;
            if (cmp_lt) begin
               lo_in = mid_ff + AW'(1);
            end else begin
               hi_in     = mid_ff;
               hi_val_in = rd_data;
            end
            state_in = ST_PIV_RD;
         end
         ST_PV: begin
            below_in = cmp_lt;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            // lo holds the rotation point; pick the run that can hold the key
            cmp_a = last_ff;
            cmp_b = key_ff;
            if (!below_ff && !cmp_lt) begin
               hi_in    = last_idx;
               state_in = ST_SR_RD;
            end else if (lo_ff != '0) begin
               hi_in    = lo_ff - AW'(1);
               lo_in    = '0;
               state_in = ST_SR_RD;
            end else begin
               res_status_in = STATUS_NOTFOUND;
               res_pos_in    = '0;
               state_in      = ST_RESULT;
            end
         end
         ST_SR_RD: begin
            rd_addr  = mid_calc;
            mid_in   = mid_calc;
            state_in = ST_SR_CMP;
         end
         ST_SR_CMP: begin
            // range empties when the step would move past the probed end
            if (cmp_eq) begin
               res_status_in = STATUS_FOUND;
               res_pos_in    = pos_of(mid_ff);
               state_in      = ST_RESULT;
            end else if (cmp_lt) begin
               if (mid_ff == lo_ff) begin
                  res_status_in = STATUS_NOTFOUND;
                  res_pos_in    = '0;
                  state_in      = ST_RESULT;
               end else begin
                  hi_in    = mid_ff - AW'(1);
                  state_in = ST_SR_RD;
               end
            end else begin
               if (mid_ff == hi_ff) begin
                  res_status_in = STATUS_NOTFOUND;
                  res_pos_in    = '0;
                  state_in      = ST_RESULT;
               end else begin
                  lo_in    = mid_ff + AW'(1);
                  state_in = ST_SR_RD;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loads when the result is ready and the slot is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESULT) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      last_ff       <= last_in;
      hi_val_ff     <= hi_val_in;
      below_ff      <= below_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_pos_ff};

endmodule

`default_nettype wire

### src/rsas_checker.sv
// port-level checker for the rotated sorted array search block
// depends on rsas_pkg; bound to rotated_sorted_array_search below
`default_nettype none

module rsas_checker
   import rsas_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // reset leaves no response pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // position only carries an index when the key was found
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_FOUND) |-> (rsp_tdata == 8'd0))
      else $error("nonzero position without a match");

   // a taken search leaves the sequencer busy, so req_tready drops
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == OP_SEARCH) |=> !req_tready)
      else $error("request taken right after a search");

   // status never shows the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_FOUND) || (rsp_tuser == STATUS_NOTFOUND)
         || (rsp_tuser == STATUS_EMPTY))
      else $error("unknown response status");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
